>>> rtl/assert_macros.svh
// Assertion shorthands; the including scope provides clk and rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLIES(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication.
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

>>> rtl/cia_pkg.sv
package cia_pkg;

    localparam int DATA_W    = 64;
    localparam int DIV_STEPS = DATA_W;
    localparam int MUL_DELAY = DIV_STEPS - 2;
    localparam int S_TDATA_W = 144;
    localparam int M_TDATA_W = 72;

    typedef enum logic [2:0] {
        OP_ADD  = 3'd0,
        OP_SUB  = 3'd1,
        OP_MUL  = 3'd2,
        OP_DIV  = 3'd3,
        OP_MOD  = 3'd4,
        OP_CAST = 3'd5
    } op_t;

    typedef enum logic [2:0] {
        ST_NONE = 3'd0,
        ST_OVF  = 3'd1,
        ST_UNF  = 3'd2,
        ST_DIVZ = 3'd3,
        ST_MODZ = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        W8  = 2'd0,
        W16 = 2'd1,
        W32 = 2'd2,
        W64 = 2'd3
    } wcode_t;

    // Operands after masking, with signs and magnitudes.
    typedef struct packed {
        logic [2:0]        op;
        logic [1:0]        wcode;
        logic [1:0]        dwcode;
        logic              sg;
        logic              dsg;
        logic              na;
        logic              nb;
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] b;
        logic [DATA_W-1:0] ma;
        logic [DATA_W-1:0] mb;
    } front_t;

    // Side data that rides along the divider.
    typedef struct packed {
        logic [2:0]        op;
        logic [1:0]        wcode;
        logic              sg;
        logic              na;
        logic              nb;
        logic              bz;
        logic [DATA_W-1:0] res;
        status_t           st;
    } side_t;

    function automatic logic [DATA_W-1:0] wmask(input logic [1:0] code);
        logic [DATA_W-1:0] m;
        case (code)
            W8:      m = 64'h0000_0000_0000_00FF;
            W16:     m = 64'h0000_0000_0000_FFFF;
            W32:     m = 64'h0000_0000_FFFF_FFFF;
            default: m = 64'hFFFF_FFFF_FFFF_FFFF;
        endcase
        return m;
    endfunction

    function automatic logic [DATA_W-1:0] wtop(input logic [1:0] code);
        logic [DATA_W-1:0] t;
        case (code)
            W8:      t = 64'h0000_0000_0000_0080;
            W16:     t = 64'h0000_0000_0000_8000;
            W32:     t = 64'h0000_0000_8000_0000;
            default: t = 64'h8000_0000_0000_0000;
        endcase
        return t;
    endfunction

    // Add, subtract and cast finish here; other ops only fill the side fields.
    function automatic side_t early(input front_t f);
        side_t             s;
        logic [DATA_W-1:0] mask;
        logic [DATA_W-1:0] top;
        logic [DATA_W-1:0] dmask;
        logic [DATA_W-1:0] dtop;
        logic [DATA_W-1:0] r;
        logic [DATA_W-1:0] v;
        mask    = wmask(f.wcode);
        top     = wtop(f.wcode);
        dmask   = wmask(f.dwcode);
        dtop    = wtop(f.dwcode);
        s.op    = f.op;
        s.wcode = f.wcode;
        s.sg    = f.sg;
        s.na    = f.na;
        s.nb    = f.nb;
        s.bz    = (f.mb == '0);
        s.res   = '0;
        s.st    = ST_NONE;
        case (f.op)
            OP_ADD:
            begin
                r     = (f.a + f.b) & mask;
                s.res = r;
                if (f.sg ? (((f.a ^ r) & (f.b ^ r) & top) != '0) : (r < f.a))
                    s.st = ST_OVF;
            end
            OP_SUB:
            begin
                r     = (f.a - f.b) & mask;
                s.res = r;
                if (f.sg ? (((f.a ^ f.b) & (f.a ^ r) & top) != '0) : (f.a < f.b))
                    s.st = ST_UNF;
            end
            OP_CAST:
            begin
                v = f.na ? (f.a | ~mask) : f.a;
                if (f.na)
                begin
                    if (!f.dsg || f.ma > dtop)
                        s.st = ST_UNF;
                end
                else if (f.a > (f.dsg ? dtop - 64'd1 : dmask))
                begin
                    s.st = ST_OVF;
                end
                s.res = (s.st == ST_NONE) ? (v & dmask) : '0;
            end
            default:
            begin
                s.res = '0;
            end
        endcase
        return s;
    endfunction

endpackage

>>> rtl/checked_integer_alu.sv
// Channel    Dir   Fields (lowest bit up)
// s_axis     in    req_type, width_code, src_signed, operand_a, operand_b,
//                  dst_width_code, dst_signed (137 bits, zero-padded to 144)
// m_axis     out   result, status (67 bits, zero-padded to 72)
//
// One item enters per cycle unless m_axis stalls; each result can leave once its
// item has passed the operand stage (loaded at the accepting edge), the 64 divider
// steps at one quotient bit each, and one output stage.
// The 64-step restoring divider sets the latency; the multiplier runs in its shadow.
// rst_n clears the valid bits of every stage; payload registers are not reset.
// A stall on m_axis freezes the whole pipeline; s_tready stays high while the
// output register is empty or being taken.
module checked_integer_alu (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // req_type, width_code, src_signed, operand_a, operand_b, dst_width_code, dst_signed
    input  logic [cia_pkg::S_TDATA_W-1:0]  s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // result, status
    output logic [cia_pkg::M_TDATA_W-1:0]  m_tdata
);
    import cia_pkg::*;

    logic              en;
    front_t            front;
    logic              front_valid;
    side_t             tag_in;
    side_t             tag_out;
    logic [DATA_W-1:0] quo;
    logic [DATA_W-1:0] rem;
    logic              div_valid;
    logic [127:0]      prod;
    logic [DATA_W-1:0] result;
    status_t           status;

    // Advance every stage together unless a finished item is held at the output.
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    // Mask operands, take signs and magnitudes.
    cia_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .en             (en),
        .in_valid       (s_tvalid),
        .req_type       (s_tdata[2:0]),
        .width_code     (s_tdata[4:3]),
        .src_signed     (s_tdata[5]),
        .operand_a      (s_tdata[69:6]),
        .operand_b      (s_tdata[133:70]),
        .dst_width_code (s_tdata[135:134]),
        .dst_signed     (s_tdata[136]),
        .front          (front),
        .front_valid    (front_valid)
    );

    // Add, subtract and cast resolve here and ride the divider as side data.
    assign tag_in = early(front);

    // Divide magnitudes; the remainder falls out of the same steps.
    cia_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (front_valid),
        .dividend  (front.ma),
        .divisor   (front.mb),
        .in_tag    (tag_in),
        .quo       (quo),
        .rem       (rem),
        .out_tag   (tag_out),
        .out_valid (div_valid)
    );

    // Full 128-bit magnitude product, delayed to line up with the divider.
    cia_mul u_mul (
        .clk  (clk),
        .en   (en),
        .ma   (front.ma),
        .mb   (front.mb),
        .prod (prod)
    );

    // Apply signs, detect range errors, hold the output register.
    cia_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (div_valid),
        .tag       (tag_out),
        .quo       (quo),
        .rem       (rem),
        .prod      (prod),
        .out_valid (m_tvalid),
        .result    (result),
        .status    (status)
    );

    assign m_tdata = {5'd0, status, result};

endmodule

>>> rtl/cia_front.sv
module cia_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            in_valid,
    input  logic [2:0]      req_type,
    input  logic [1:0]      width_code,
    input  logic            src_signed,
    input  logic [63:0]     operand_a,
    input  logic [63:0]     operand_b,
    input  logic [1:0]      dst_width_code,
    input  logic            dst_signed,
    output cia_pkg::front_t front,
    output logic            front_valid
);
    import cia_pkg::*;

    logic [DATA_W-1:0] mask;
    logic [DATA_W-1:0] top;
    front_t            front_next;
    front_t            front_reg;
    logic              valid_reg;

    always_comb
    begin
        mask              = wmask(width_code);
        top               = wtop(width_code);
        front_next.op     = req_type;
        front_next.wcode  = width_code;
        front_next.dwcode = dst_width_code;
        front_next.sg     = src_signed;
        front_next.dsg    = dst_signed;
        front_next.a      = operand_a & mask;
        front_next.b      = operand_b & mask;
        front_next.na     = src_signed && ((front_next.a & top) != '0);
        front_next.nb     = src_signed && ((front_next.b & top) != '0);
        front_next.ma     = front_next.na ? ((64'd0 - front_next.a) & mask) : front_next.a;
        front_next.mb     = front_next.nb ? ((64'd0 - front_next.b) & mask) : front_next.b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            front_reg <= front_next;
    end

    assign front       = front_reg;
    assign front_valid = valid_reg;

endmodule

>>> rtl/cia_mul.sv
module cia_mul (
    input  logic         clk,
    input  logic         en,
    input  logic [63:0]  ma,
    input  logic [63:0]  mb,
    output logic [127:0] prod
);
    import cia_pkg::*;

    logic [63:0]  pp_ll_reg;
    logic [63:0]  pp_lh_reg;
    logic [63:0]  pp_hl_reg;
    logic [63:0]  pp_hh_reg;
    logic [127:0] sum_next;
    logic [127:0] sum_reg;
    logic [127:0] dly_reg [MUL_DELAY];

    // Four 32x32 partial products, then one sum.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pp_ll_reg <= ma[31:0]  * mb[31:0];
            pp_lh_reg <= ma[31:0]  * mb[63:32];
            pp_hl_reg <= ma[63:32] * mb[31:0];
            pp_hh_reg <= ma[63:32] * mb[63:32];
        end
    end

    assign sum_next = {pp_hh_reg, pp_ll_reg}
                    + {32'd0, pp_lh_reg, 32'd0}
                    + {32'd0, pp_hl_reg, 32'd0};

    always_ff @(posedge clk)
    begin
        if (en)
            sum_reg <= sum_next;
    end

    // Align the product with the divider output.
    for (genvar k = 0; k < MUL_DELAY; k++)
    begin : g_dly
        always_ff @(posedge clk)
        begin
            if (en)
                dly_reg[k] <= (k == 0) ? sum_reg : dly_reg[(k == 0) ? 0 : k - 1];
        end
    end

    assign prod = dly_reg[MUL_DELAY-1];

endmodule

>>> rtl/cia_div.sv
module cia_div (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  logic           in_valid,
    input  logic [63:0]    dividend,
    input  logic [63:0]    divisor,
    input  cia_pkg::side_t in_tag,
    output logic [63:0]    quo,
    output logic [63:0]    rem,
    output cia_pkg::side_t out_tag,
    output logic           out_valid
);
    import cia_pkg::*;

    logic [DATA_W-1:0]    rem_reg [DIV_STEPS];
    logic [DATA_W-1:0]    dvd_reg [DIV_STEPS];
    logic [DATA_W-1:0]    dvs_reg [DIV_STEPS];
    side_t                tag_reg [DIV_STEPS];
    logic [DIV_STEPS-1:0] vld_reg;

    // One restoring step per stage; the dividend shifts out as quotient bits shift in.
    for (genvar k = 0; k < DIV_STEPS; k++)
    begin : g_step
        logic [DATA_W-1:0] rem_in;
        logic [DATA_W-1:0] dvd_in;
        logic [DATA_W-1:0] dvs_in;
        side_t             tag_in;
        logic              vld_in;
        logic [DATA_W:0]   trial;
        logic [DATA_W:0]   diff;
        logic              fit;
        logic [DATA_W-1:0] rem_next;
        logic [DATA_W-1:0] dvd_next;

        if (k == 0)
        begin : g_head
            assign rem_in = '0;
            assign dvd_in = dividend;
            assign dvs_in = divisor;
            assign tag_in = in_tag;
            assign vld_in = in_valid;
        end
        else
        begin : g_body
            assign rem_in = rem_reg[k-1];
            assign dvd_in = dvd_reg[k-1];
            assign dvs_in = dvs_reg[k-1];
            assign tag_in = tag_reg[k-1];
            assign vld_in = vld_reg[k-1];
        end

        assign trial    = {rem_in, dvd_in[DATA_W-1]};
        assign diff     = trial - {1'b0, dvs_in};
        assign fit      = !diff[DATA_W];
        assign rem_next = fit ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
        assign dvd_next = {dvd_in[DATA_W-2:0], fit};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[k] <= 1'b0;
            else if (en)
                vld_reg[k] <= vld_in;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k] <= rem_next;
                dvd_reg[k] <= dvd_next;
                dvs_reg[k] <= dvs_in;
                tag_reg[k] <= tag_in;
            end
        end
    end

    assign quo       = dvd_reg[DIV_STEPS-1];
    assign rem       = rem_reg[DIV_STEPS-1];
    assign out_tag   = tag_reg[DIV_STEPS-1];
    assign out_valid = vld_reg[DIV_STEPS-1];

endmodule

>>> rtl/cia_back.sv
module cia_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_valid,
    input  cia_pkg::side_t   tag,
    input  logic [63:0]      quo,
    input  logic [63:0]      rem,
    input  logic [127:0]     prod,
    output logic             out_valid,
    output logic [63:0]      result,
    output cia_pkg::status_t status
);
    import cia_pkg::*;

    logic [DATA_W-1:0] mask;
    logic [DATA_W-1:0] top;
    logic [DATA_W-1:0] lim;
    logic              neg;
    logic [DATA_W-1:0] result_next;
    status_t           status_next;
    logic [DATA_W-1:0] result_reg;
    status_t           status_reg;
    logic              valid_reg;

    always_comb
    begin
        mask        = wmask(tag.wcode);
        top         = wtop(tag.wcode);
        neg         = tag.na ^ tag.nb;
        lim         = tag.sg ? (neg ? top : top - 64'd1) : mask;
        result_next = '0;
        status_next = ST_NONE;
        case (tag.op)
            OP_ADD, OP_SUB, OP_CAST:
            begin
                result_next = tag.res;
                status_next = tag.st;
            end
            OP_MUL:
            begin
                result_next = (neg ? (64'd0 - prod[63:0]) : prod[63:0]) & mask;
                if ((prod[127:64] != '0) || (prod[63:0] > lim))
                    status_next = ST_OVF;
            end
            OP_DIV:
            begin
                if (tag.bz)
                    status_next = ST_DIVZ;
                else if (!tag.sg)
                    result_next = quo;
                else
                begin
                    result_next = (neg ? (64'd0 - quo) : quo) & mask;
                    if (!neg && (quo > top - 64'd1))
                        status_next = ST_OVF;
                end
            end
            OP_MOD:
            begin
                if (tag.bz)
                    status_next = ST_MODZ;
                else if (!tag.sg)
                    result_next = rem;
                else
                    result_next = (tag.na ? (64'd0 - rem) : rem) & mask;
            end
            default:
            begin
                result_next = '0;
                status_next = ST_NONE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            result_reg <= result_next;
            status_reg <= status_next;
        end
    end

    assign out_valid = valid_reg;
    assign result    = result_reg;
    assign status    = status_reg;

endmodule

>>> rtl/cia_checker.sv
module cia_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [cia_pkg::M_TDATA_W-1:0] m_tdata
);
    import cia_pkg::*;
`include "assert_macros.svh"

    `ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    `ASSERT_IMPLIES(a_ready_rule, s_tvalid || !s_tvalid, s_tready == (!m_tvalid || m_tready))
    `ASSERT_IMPLIES(a_status_range, m_tvalid, m_tdata[66:64] <= ST_MODZ)
    `ASSERT_IMPLIES(a_zero_div, m_tvalid && (m_tdata[66:64] == ST_DIVZ || m_tdata[66:64] == ST_MODZ), m_tdata[63:0] == 64'd0)
    `ASSERT_IMPLIES(a_pad_zero, m_tvalid, m_tdata[71:67] == 5'd0)

endmodule

bind checked_integer_alu cia_checker u_cia_checker (.*);
